FILE: src/assert_macros.svh
// Assertion macros used by sorted_key_list_engine.sv.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: src/skl_pkg.sv
// Package for the sorted key list engine: operation and status codes,
// the token that walks the cell chain, and controller state type.
// No dependencies.
package skl_pkg;

	localparam int KEY_W = 32;
	localparam int POS_W = 6;
	localparam int CNT_OUT_W = 7;

	localparam logic [2:0] FN_INSERT        = 3'd0;
	localparam logic [2:0] FN_INSERT_UNIQUE = 3'd1;
	localparam logic [2:0] FN_POP           = 3'd2;
	localparam logic [2:0] FN_DELETE        = 3'd3;
	localparam logic [2:0] FN_SEARCH        = 3'd4;
	localparam logic [2:0] FN_CLEAR         = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_DUPLICATE = 3'd4;

	typedef enum logic [1:0] {
		TM_SEEK,
		TM_INS,
		TM_DEL,
		TM_DONE
	} tok_mode_t;

	// operation token handed from cell to cell; carries the result with it
	typedef struct packed {
		logic             active;
		tok_mode_t        mode;
		logic [2:0]       func;
		logic [KEY_W-1:0] key;      // search key, or displaced key while inserting
		logic [2:0]       status;
		logic [KEY_W-1:0] key_out;
		logic [POS_W-1:0] pos;
	} tok_t;

	typedef enum logic {
		CS_IDLE,
		CS_BUSY
	} ctrl_state_t;

endpackage

FILE: src/skl_cell.sv
// One cell of the key chain: holds one stored key, acts on the token
// passing through and hands the token to the next cell. Uses skl_pkg.
module skl_cell #(
	parameter int CW = 7,
	parameter logic [CW-1:0] IDX = '0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [CW-1:0]             cnt,
	input  logic                      full,
	input  skl_pkg::tok_t             tok_in,
	input  logic [skl_pkg::KEY_W-1:0] key_next,
	output logic [skl_pkg::KEY_W-1:0] key,
	output skl_pkg::tok_t             tok_out
);

	localparam logic [skl_pkg::POS_W-1:0] POS = skl_pkg::POS_W'(IDX);

	logic [skl_pkg::KEY_W-1:0] key_q;
	logic [skl_pkg::KEY_W-1:0] key_d;
	skl_pkg::tok_t             tok_q;
	skl_pkg::tok_t             nt;
	logic                      used;
	logic                      is_ins;

	assign used   = IDX < cnt;
	assign is_ins = (tok_in.func == skl_pkg::FN_INSERT) ||
		(tok_in.func == skl_pkg::FN_INSERT_UNIQUE);

	always_comb begin
		nt    = tok_in;
		key_d = key_q;
		if (tok_in.active) begin
			case (tok_in.mode)
				skl_pkg::TM_SEEK: begin
					if (!used) begin
						// ran past the stored keys
						if (is_ins) begin
							key_d     = tok_in.key;
							nt.status = skl_pkg::ST_OK;
							nt.pos    = POS;
						end else begin
							nt.status = skl_pkg::ST_NOT_FOUND;
						end
						nt.mode = skl_pkg::TM_DONE;
					end else if (tok_in.func == skl_pkg::FN_POP) begin
						nt.key_out = key_q;
						nt.pos     = POS;
						nt.mode    = skl_pkg::TM_DEL;
						key_d      = key_next;
					end else if ($signed(key_q) <= $signed(tok_in.key)) begin
						if ((key_q == tok_in.key) && (tok_in.func != skl_pkg::FN_INSERT)) begin
							nt.key_out = key_q;
							nt.pos     = POS;
							nt.mode    = skl_pkg::TM_DONE;
							if (tok_in.func == skl_pkg::FN_INSERT_UNIQUE) begin
								nt.status = skl_pkg::ST_DUPLICATE;
							end else if (tok_in.func == skl_pkg::FN_DELETE) begin
								nt.mode = skl_pkg::TM_DEL;
								key_d   = key_next;
							end
						end else if (is_ins) begin
							if (full) begin
								nt.status = skl_pkg::ST_FULL;
								nt.mode   = skl_pkg::TM_DONE;
							end else begin
								key_d     = tok_in.key;
								nt.key    = key_q;
								nt.pos    = POS;
								nt.status = skl_pkg::ST_OK;
								nt.mode   = skl_pkg::TM_INS;
							end
						end else begin
							// sorted order: no match further down
							nt.status = skl_pkg::ST_NOT_FOUND;
							nt.mode   = skl_pkg::TM_DONE;
						end
					end
				end
				skl_pkg::TM_INS: begin
					key_d  = tok_in.key;
					nt.key = key_q;
				end
				skl_pkg::TM_DEL: begin
					key_d = key_next;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= nt;
		end
	end

	assign key     = key_q;
	assign tok_out = tok_q;

endmodule

FILE: src/sorted_key_list_engine.sv
// Sorted key list engine: s_* carries {key, func}, m_* carries
// {entry_count, position, key_out, status}, one result per transfer in.
// Keys are kept in descending order, head (position 0) largest.
// An accepted operation enters a chain of TABLE_DEPTH cells as a token and
// moves one cell per cycle; each cell compares, inserts, shifts or pulls its
// neighbor's key as the token passes. Inserts push keys toward the tail,
// pops and deletes pull them toward the head.
// The token is registered at the chain entry and in every cell, and the
// result in the output register before m_tvalid. A new item is taken
// only after the token has walked the full chain; s_tready is low while
// a token is in flight. Output: a result register plus a one-entry skid;
// a new item is taken while a result waits, and while idle s_tready drops
// only when the skid is also full. A stalled m_tready never loses a result.
// Reset (arst_n low): the table is empty, no token in flight, no result
// pending. Stored keys need no clearing; only entries below the count are
// read.
// Uses skl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sorted_key_list_engine #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // func[2:0], key[34:3], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status[2:0], key_out[34:3], position[40:35],
	                               // entry_count[47:41]
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

	skl_pkg::ctrl_state_t state_q, state_d;
	logic [CW-1:0]        cnt_q;
	skl_pkg::tok_t        tok [TABLE_DEPTH+1];
	logic [skl_pkg::KEY_W-1:0] keys [TABLE_DEPTH];
	skl_pkg::tok_t        tok_end;
	logic                 full;
	logic                 accept;
	logic [2:0]           in_func;
	logic [skl_pkg::KEY_W-1:0] in_key;
	skl_pkg::tok_t        launch;

	logic [2:0]           res_status;
	logic [CW-1:0]        res_cnt;
	logic [47:0]          res_data;
	logic                 take;
	logic                 out_valid_q, skid_valid_q;
	logic [47:0]          out_q, skid_q;

	assign in_func = s_tdata[2:0];
	assign in_key  = s_tdata[34:3];
	assign full    = cnt_q == FULL_CNT;
	assign accept  = s_tvalid && s_tready;

	// controller state
	always_comb begin
		state_d = state_q;
		case (state_q)
			skl_pkg::CS_IDLE: if (accept) state_d = skl_pkg::CS_BUSY;
			skl_pkg::CS_BUSY: if (tok_end.active) state_d = skl_pkg::CS_IDLE;
			default: state_d = skl_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			skl_pkg::CS_IDLE: s_tready = !skid_valid_q;
			default:          s_tready = 1'b0;
		endcase
	end

	// token entering the chain; trivial cases travel as finished tokens
	always_comb begin
		launch         = '0;
		launch.active  = accept;
		launch.func    = in_func;
		launch.key     = in_key;
		launch.status  = skl_pkg::ST_OK;
		launch.mode    = skl_pkg::TM_SEEK;
		case (in_func)
			skl_pkg::FN_INSERT: if (full) begin
				launch.status = skl_pkg::ST_FULL;
				launch.mode   = skl_pkg::TM_DONE;
			end
			skl_pkg::FN_POP: if (cnt_q == '0) begin
				launch.status = skl_pkg::ST_EMPTY;
				launch.mode   = skl_pkg::TM_DONE;
			end
			skl_pkg::FN_INSERT_UNIQUE, skl_pkg::FN_DELETE, skl_pkg::FN_SEARCH: begin
			end
			default: launch.mode = skl_pkg::TM_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok[0] <= '0;
		end else begin
			tok[0] <= launch;
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [skl_pkg::KEY_W-1:0] nb_key;
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign nb_key = keys[i];
		end else begin : g_mid
			assign nb_key = keys[i+1];
		end
		skl_cell #(
			.CW  (CW),
			.IDX (CW'(i))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cnt      (cnt_q),
			.full     (full),
			.tok_in   (tok[i]),
			.key_next (nb_key),
			.key      (keys[i]),
			.tok_out  (tok[i+1])
		);
	end

	assign tok_end = tok[TABLE_DEPTH];

	// result at the end of the chain
	always_comb begin
		res_status = tok_end.status;
		if (tok_end.mode == skl_pkg::TM_SEEK) begin
			// every stored key greater than the search key
			if ((tok_end.func == skl_pkg::FN_INSERT) ||
				(tok_end.func == skl_pkg::FN_INSERT_UNIQUE)) begin
				res_status = skl_pkg::ST_FULL;
			end else begin
				res_status = skl_pkg::ST_NOT_FOUND;
			end
		end
		res_cnt = cnt_q;
		if (tok_end.func == skl_pkg::FN_CLEAR) begin
			res_cnt = '0;
		end else if (res_status == skl_pkg::ST_OK) begin
			if ((tok_end.func == skl_pkg::FN_INSERT) ||
				(tok_end.func == skl_pkg::FN_INSERT_UNIQUE)) begin
				res_cnt = cnt_q + CW'(1);
			end else if ((tok_end.func == skl_pkg::FN_POP) ||
				(tok_end.func == skl_pkg::FN_DELETE)) begin
				res_cnt = cnt_q - CW'(1);
			end
		end
		if (tok_end.mode == skl_pkg::TM_SEEK) begin
			res_data = {skl_pkg::CNT_OUT_W'(res_cnt), {skl_pkg::POS_W{1'b0}},
				{skl_pkg::KEY_W{1'b0}}, res_status};
		end else begin
			res_data = {skl_pkg::CNT_OUT_W'(res_cnt), tok_end.pos, tok_end.key_out,
				res_status};
		end
	end

	assign take = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= skl_pkg::CS_IDLE;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tok_end.active) begin
				cnt_q <= res_cnt;
				// skid is always empty when a token arrives
				if (!out_valid_q || take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_end.active) begin
			if (!out_valid_q || take) begin
				out_q <= res_data;
			end else begin
				skid_q <= res_data;
			end
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	`ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= FULL_CNT, "entry count over depth")
	`ASSERT_NEXT(a_launch_busy, clk, arst_n, accept, state_q == skl_pkg::CS_BUSY, "no busy after transfer")
	`ASSERT_IMPL(a_skid_order, clk, arst_n, skid_valid_q, out_valid_q, "skid full with output empty")
	`ASSERT_IMPL(a_end_busy, clk, arst_n, tok_end.active, state_q == skl_pkg::CS_BUSY, "token arrived while idle")

endmodule
